/* sv/flt_pkg.sv */
// shared types, constants and helpers for the frame load throttle governor
package flt_pkg;

  localparam int COST_W  = 16;
  localparam int SCORE_W = 8;
  localparam int AVG_W   = 15;
  localparam int TGT_W   = 15;
  localparam int SCL_W   = 4;
  localparam int EDGE_W  = 13;
  localparam int FPS_W   = 8;
  localparam int LVL_W   = 3;
  localparam int PCT_W   = 7;
  localparam int IDX_W   = 2;
  localparam int CFG_W   = 13;

  // register indexes of the config port
  localparam logic [IDX_W-1:0] REG_BASE_EDGE = 2'd0;
  localparam logic [IDX_W-1:0] REG_REQ_FPS   = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_FPS   = 2'd2;

  localparam logic [EDGE_W-1:0] RST_BASE_EDGE = 13'd1920;
  localparam logic [FPS_W-1:0]  RST_REQ_FPS   = 8'd30;
  localparam logic [FPS_W-1:0]  RST_MIN_FPS   = 8'd15;

  localparam logic [EDGE_W-1:0] EDGE_FLOOR = 13'd240;
  localparam logic [SCL_W-1:0]  SCORE_MAX  = 4'd12;

  // throttle levels
  localparam logic [LVL_W-1:0] LVL_NONE     = 3'd0;
  localparam logic [LVL_W-1:0] LVL_LIGHT    = 3'd1;
  localparam logic [LVL_W-1:0] LVL_MODERATE = 3'd2;
  localparam logic [LVL_W-1:0] LVL_SEVERE   = 3'd3;
  localparam logic [LVL_W-1:0] LVL_CRITICAL = 3'd4;

  // pressure thresholds in percent of target, and score thresholds
  localparam logic [7:0] PRESS_LIGHT    = 8'd108;
  localparam logic [7:0] PRESS_MODERATE = 8'd135;
  localparam logic [7:0] PRESS_SEVERE   = 8'd175;
  localparam logic [7:0] PRESS_CRITICAL = 8'd230;
  localparam logic [SCL_W-1:0] SCORE_LIGHT    = 4'd2;
  localparam logic [SCL_W-1:0] SCORE_MODERATE = 4'd5;
  localparam logic [SCL_W-1:0] SCORE_SEVERE   = 4'd8;
  localparam logic [SCL_W-1:0] SCORE_CRITICAL = 4'd10;

  // x/5 = (x*DIV5_MUL) >> DIV5_SH, exact for x < 2^18
  localparam logic [17:0] DIV5_MUL = 18'd209716;
  localparam int          DIV5_SH  = 20;
  // x/100 = (x*DIV100_MUL) >> DIV100_SH, exact for x < 2^20
  localparam logic [20:0] DIV100_MUL = 21'd1342178;
  localparam int          DIV100_SH  = 27;

  typedef struct packed {
    logic [AVG_W-1:0] cost;
    logic [TGT_W-1:0] tgt;
    logic [SCL_W-1:0] score;
  } flt_frame_t;

  function automatic logic [PCT_W-1:0] scale_pct(input logic [LVL_W-1:0] lvl);
    logic [PCT_W-1:0] p;
    case (lvl)
      LVL_NONE:     p = 7'd100;
      LVL_LIGHT:    p = 7'd92;
      LVL_MODERATE: p = 7'd82;
      LVL_SEVERE:   p = 7'd70;
      LVL_CRITICAL: p = 7'd55;
      default:      p = 7'd100;
    endcase
    return p;
  endfunction

endpackage

/* sv/flt_smooth.sv */
// smoothed render cost update: load on zero, else (4*avg+cost)/5
module flt_smooth
  import flt_pkg::*;
(
  input  logic [AVG_W-1:0] avg,
  input  logic [AVG_W-1:0] cost,
  output logic [AVG_W-1:0] avg_new
);

  logic [17:0] sum;
  logic [35:0] prod;

  assign sum  = {1'b0, avg, 2'b00} + {3'b000, cost};
  // reciprocal multiply, sum stays below 2^18
  assign prod = {18'd0, sum} * {18'd0, DIV5_MUL};

  always_comb begin
    if (avg == '0) begin
      avg_new = cost;
    end else begin
      avg_new = prod[DIV5_SH +: AVG_W];
    end
  end

endmodule

/* sv/flt_level.sv */
// throttle level pick from smoothed cost, target and overload score
module flt_level
  import flt_pkg::*;
(
  input  logic [AVG_W-1:0] avg,
  input  logic [TGT_W-1:0] tgt,
  input  logic [SCL_W-1:0] score,
  output logic [LVL_W-1:0] level
);

  logic [22:0] lhs;
  logic [22:0] rhs_light;
  logic [22:0] rhs_moderate;
  logic [22:0] rhs_severe;
  logic [22:0] rhs_critical;

  assign lhs          = 23'({8'd0, avg} * 23'd100);
  assign rhs_light    = 23'({8'd0, tgt} * {15'd0, PRESS_LIGHT});
  assign rhs_moderate = 23'({8'd0, tgt} * {15'd0, PRESS_MODERATE});
  assign rhs_severe   = 23'({8'd0, tgt} * {15'd0, PRESS_SEVERE});
  assign rhs_critical = 23'({8'd0, tgt} * {15'd0, PRESS_CRITICAL});

  // first match from the top wins
  always_comb begin
    if (score >= SCORE_CRITICAL || lhs >= rhs_critical) begin
      level = LVL_CRITICAL;
    end else if (score >= SCORE_SEVERE || lhs >= rhs_severe) begin
      level = LVL_SEVERE;
    end else if (score >= SCORE_MODERATE || lhs >= rhs_moderate) begin
      level = LVL_MODERATE;
    end else if (score >= SCORE_LIGHT || lhs >= rhs_light) begin
      level = LVL_LIGHT;
    end else begin
      level = LVL_NONE;
    end
  end

endmodule

/* sv/frame_load_throttle_governor_unit.sv */
// top level of the frame load throttle governor
// an accepted input beat passes stages 1 to 4 and the result register before its result beat shows on out_*
// throughput: one beat per cycle; a stage holds only while the next one is full and
//   blocked, so a stalled result stops intake once all five stages are full
// reset (rst_n low, synchronous) empties the pipeline, zeroes the average and
//   loads the config registers with 1920 px, 30 fps and 15 fps
module frame_load_throttle_governor_unit
  import flt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      cfg_we,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COST_W-1:0]  in_render_cost,
  input  logic signed [COST_W-1:0]  in_target_frame,
  input  logic signed [SCORE_W-1:0] in_overload_score,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [LVL_W-1:0]          out_throttle_level,
  output logic [EDGE_W-1:0]         out_preview_edge_px,
  output logic [FPS_W-1:0]          out_preview_fps,
  output logic [AVG_W-1:0]          out_average_cost
);

  // config registers
  logic [EDGE_W-1:0] base_edge_r;
  logic [FPS_W-1:0]  req_fps_r;
  logic [FPS_W-1:0]  min_fps_r;

  // pipeline valids and per-stage ready
  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic rdy1, rdy2, rdy3, rdy4, rdyo;

  // stage 1: cleaned input beat
  flt_frame_t s1_r, s1_nxt;
  // stage 2: updated average (the running state) and what level pick needs
  logic [AVG_W-1:0] avg_r, avg_nxt;
  logic [TGT_W-1:0] s2_tgt_r;
  logic [SCL_W-1:0] s2_score_r;
  // stage 3: level
  logic [LVL_W-1:0] s3_lvl_r, lvl_nxt;
  logic [AVG_W-1:0] s3_avg_r;
  // stage 4: scaled products before the divide by 100
  logic [LVL_W-1:0] s4_lvl_r;
  logic [AVG_W-1:0] s4_avg_r;
  logic [19:0]      s4_edge_prod_r, edge_prod_nxt;
  logic [14:0]      s4_fps_prod_r, fps_prod_nxt;
  // result register
  logic [LVL_W-1:0]  out_lvl_r;
  logic [EDGE_W-1:0] out_edge_r, edge_nxt;
  logic [FPS_W-1:0]  out_fps_r, fps_nxt;
  logic [AVG_W-1:0]  out_avg_r;

  logic [PCT_W-1:0]  pct;
  logic [FPS_W-1:0]  req_eff;
  logic [FPS_W-1:0]  min_eff;
  logic [40:0]       edge_quot_full;
  logic [35:0]       fps_quot_full;
  logic [EDGE_W-1:0] edge_q;
  logic [FPS_W-1:0]  fps_q;

  // ready chain: a stage may load when it is empty or its content moves on
  assign rdyo = !vo_r || !out_stall;
  assign rdy4 = !v4_r || rdyo;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // input cleanup: negative cost to zero, target at least 1, score 0..12
  always_comb begin
    s1_nxt.cost = in_render_cost[COST_W-1] ? '0 : in_render_cost[AVG_W-1:0];
    if (in_target_frame[COST_W-1] || in_target_frame == '0) begin
      s1_nxt.tgt = TGT_W'(1);
    end else begin
      s1_nxt.tgt = in_target_frame[TGT_W-1:0];
    end
    if (in_overload_score[SCORE_W-1]) begin
      s1_nxt.score = '0;
    end else if (in_overload_score > $signed({{(SCORE_W-SCL_W){1'b0}}, SCORE_MAX})) begin
      s1_nxt.score = SCORE_MAX;
    end else begin
      s1_nxt.score = in_overload_score[SCL_W-1:0];
    end
  end

  // averaging loop, avg_r doubles as stage 2 payload
  flt_smooth u_smooth (
    .avg     (avg_r),
    .cost    (s1_r.cost),
    .avg_new (avg_nxt)
  );

  flt_level u_level (
    .avg   (avg_r),
    .tgt   (s2_tgt_r),
    .score (s2_score_r),
    .level (lvl_nxt)
  );

  // scale by level percentage, +50 for round half up
  assign pct           = scale_pct(s3_lvl_r);
  assign req_eff       = (req_fps_r == '0) ? FPS_W'(1) : req_fps_r;
  assign edge_prod_nxt = 20'({7'd0, base_edge_r} * {13'd0, pct}) + 20'd50;
  assign fps_prod_nxt  = 15'({7'd0, req_eff} * {8'd0, pct}) + 15'd50;

  // divide by 100 through the reciprocal
  assign edge_quot_full = {21'd0, s4_edge_prod_r} * {20'd0, DIV100_MUL};
  assign fps_quot_full  = {21'd0, s4_fps_prod_r} * {15'd0, DIV100_MUL};
  assign edge_q = edge_quot_full[DIV100_SH +: EDGE_W];
  assign fps_q  = fps_quot_full[DIV100_SH +: FPS_W];

  // fps floor is min(min_fps, requested), never below 1
  always_comb begin
    if (min_fps_r < req_eff) begin
      min_eff = (min_fps_r == '0) ? FPS_W'(1) : min_fps_r;
    end else begin
      min_eff = req_eff;
    end
  end

  // edge rules: zero base gives zero, small base passes, else clamp 240..base
  always_comb begin
    if (base_edge_r == '0) begin
      edge_nxt = '0;
    end else if (base_edge_r < EDGE_FLOOR) begin
      edge_nxt = base_edge_r;
    end else if (edge_q < EDGE_FLOOR) begin
      edge_nxt = EDGE_FLOOR;
    end else if (edge_q > base_edge_r) begin
      edge_nxt = base_edge_r;
    end else begin
      edge_nxt = edge_q;
    end
  end

  always_comb begin
    if (fps_q < min_eff) begin
      fps_nxt = min_eff;
    end else if (fps_q > req_eff) begin
      fps_nxt = req_eff;
    end else begin
      fps_nxt = fps_q;
    end
  end

  // config writes, out-of-range index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_edge_r <= RST_BASE_EDGE;
      req_fps_r   <= RST_REQ_FPS;
      min_fps_r   <= RST_MIN_FPS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_EDGE: base_edge_r <= cfg_wdata;
        REG_REQ_FPS:   req_fps_r   <= cfg_wdata[FPS_W-1:0];
        REG_MIN_FPS:   min_fps_r   <= cfg_wdata[FPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control: valids and running average
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      vo_r  <= 1'b0;
      avg_r <= '0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdyo) vo_r <= v4_r;
      // the average moves only when a beat enters stage 2
      if (rdy2 && v1_r) avg_r <= avg_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (rdy2 && v1_r) begin
      s2_tgt_r   <= s1_r.tgt;
      s2_score_r <= s1_r.score;
    end
    if (rdy3 && v2_r) begin
      s3_lvl_r <= lvl_nxt;
      s3_avg_r <= avg_r;
    end
    if (rdy4 && v3_r) begin
      s4_lvl_r       <= s3_lvl_r;
      s4_avg_r       <= s3_avg_r;
      s4_edge_prod_r <= edge_prod_nxt;
      s4_fps_prod_r  <= fps_prod_nxt;
    end
    if (rdyo && v4_r) begin
      out_lvl_r  <= s4_lvl_r;
      out_avg_r  <= s4_avg_r;
      out_edge_r <= edge_nxt;
      out_fps_r  <= fps_nxt;
    end
  end

  assign out_valid           = vo_r;
  assign out_throttle_level  = out_lvl_r;
  assign out_preview_edge_px = out_edge_r;
  assign out_preview_fps     = out_fps_r;
  assign out_average_cost    = out_avg_r;

endmodule
